// ===== rtl/modexp_pkg.sv =====
// types and constants shared by the modular exponentiation unit
// used by modexp_ctrl, modexp_dp and modular_exponentiation_unit; no dependencies
`default_nettype none

package modexp_pkg;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] EXPONENT_RESET = 32'd17;
    localparam logic [CFG_DATA_W-1:0] MODULUS_RESET  = 32'd3233;

    // which product the shared multiplier forms, and where the residue goes
    typedef enum logic [1:0] {
        MUL_BASE,    // base * 1 -> sq
        MUL_ACC_SQ,  // acc * sq -> acc
        MUL_SQ_SQ    // sq * sq  -> sq
    } t_mul_op;

    typedef enum logic [1:0] {
        RES_BASE,
        RES_ZERO,
        RES_ACC
    } t_res_sel;

    typedef struct packed {
        logic     load;    // capture base, exponent, last flag; acc = 1
        logic     mul;     // register the product, clear the remainder
        logic     red;     // one restoring-division step
        logic     wb;      // write the remainder back
        logic     shift;   // exponent >> 1
        logic     res_we;  // capture the result
        t_mul_op  op;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_lt2;
        logic mod_lt2;
        logic exp_lsb;
        logic exp_hi_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/modular_exponentiation_unit.sv =====
// top level of the modular exponentiation unit: configuration registers,
// controller and datapath; depends on modexp_pkg, modexp_ctrl, modexp_dp
//
//   port group   direction  handshake               payload
//   request      in         i_start / o_busy        i_base_value, i_is_last
//   result       out        o_done (one-cycle)      o_power_value, o_last_out
//   config       in         i_cfg_we                i_cfg_index, i_cfg_data
//
// a request is taken when i_start is high and o_busy is low; exponent or modulus below 2:
// the result is registered straight from the check state
// otherwise each square or multiply goes through the product register, the bit-serial reducer
// and the write-back; o_busy drops with o_done, so the next request
// can go in at the result edge; synchronous active-low reset; o_done is never held
`default_nettype none

module modular_exponentiation_unit
    import modexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_base_value,
    input  wire logic                   i_is_last,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_power_value,
    output logic                        o_last_out,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [VALUE_WIDTH-1:0] r_exponent, r_modulus;
    t_dp_cmd                cmd;
    t_dp_stat               stat;

    // only the low VALUE_WIDTH bits of each register are ever used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RESET[VALUE_WIDTH-1:0];
            r_modulus  <= MODULUS_RESET[VALUE_WIDTH-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPONENT: r_exponent <= i_cfg_data[VALUE_WIDTH-1:0];
                CFG_MODULUS:  r_modulus  <= i_cfg_data[VALUE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    modexp_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    modexp_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_base_value  (i_base_value),
        .i_is_last     (i_is_last),
        .i_exponent    (r_exponent),
        .i_modulus     (r_modulus),
        .o_stat        (stat),
        .o_power_value (o_power_value),
        .o_last_out    (o_last_out)
    );

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> $stable(r_exponent) && $stable(r_modulus))
        else $error("configuration changed while busy");

endmodule

`default_nettype wire

// ===== rtl/modexp_ctrl.sv =====
// controller of the modular exponentiation unit: square-and-multiply sequencing
// depends on modexp_pkg; drives modexp_dp through t_dp_cmd, reads t_dp_stat
`default_nettype none

module modexp_ctrl
    import modexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    localparam int CNT_W = $clog2(2 * VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_RED,
        S_WB,
        S_BIT,
        S_NEXT
    } t_state;

    t_state           r_state, n_state;
    t_mul_op          r_op, n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.op      = r_op;
        o_cmd.res_sel = RES_ACC;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.exp_lt2) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_BASE;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_stat.mod_lt2) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_ZERO;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_op    = MUL_BASE;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_RED;
            end
            S_RED: begin
                o_cmd.red = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                case (r_op)
                    MUL_BASE:   n_state = S_BIT;
                    MUL_ACC_SQ: n_state = S_NEXT;
                    MUL_SQ_SQ: begin
                        o_cmd.shift = 1'b1;
                        n_state     = S_BIT;
                    end
                    default:    n_state = S_IDLE;
                endcase
            end
            S_BIT: begin
                if (i_stat.exp_lsb) begin
                    n_op    = MUL_ACC_SQ;
                    n_state = S_MUL;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                // no more exponent bits: the last square is not needed
                if (i_stat.exp_hi_zero) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_ACC;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_op    = MUL_SQ_SQ;
                    n_state = S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= MUL_BASE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while still working");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> r_state == S_CHECK)
        else $error("request not taken");

endmodule

`default_nettype wire

// ===== rtl/modexp_dp.sv =====
// datapath of the modular exponentiation unit: multiplier, bit-serial reducer,
// acc / sq / exponent registers; depends on modexp_pkg, driven by modexp_ctrl
`default_nettype none

module modexp_dp
    import modexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic [VALUE_WIDTH-1:0] i_base_value,
    input  wire logic                   i_is_last,
    input  wire logic [VALUE_WIDTH-1:0] i_exponent,
    input  wire logic [VALUE_WIDTH-1:0] i_modulus,
    output t_dp_stat                    o_stat,
    output logic [VALUE_WIDTH-1:0]      o_power_value,
    output logic                        o_last_out
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0]   r_base, r_exp, r_acc, r_sq, r_rem, r_result;
    logic [2*W-1:0] r_prod;
    logic           r_last, r_last_out;

    logic [W-1:0]   mul_a, mul_b, rem_next;
    logic [2*W-1:0] prod;
    logic [W:0]     trial;

    always_comb begin
        case (i_cmd.op)
            MUL_BASE: begin
                mul_a = r_base;
                mul_b = W'(1);
            end
            MUL_ACC_SQ: begin
                mul_a = r_acc;
                mul_b = r_sq;
            end
            MUL_SQ_SQ: begin
                mul_a = r_sq;
                mul_b = r_sq;
            end
            default: begin
                mul_a = r_sq;
                mul_b = r_sq;
            end
        endcase
    end

    assign prod = (2*W)'(mul_a) * (2*W)'(mul_b);

    // restoring division step: bring in the next product bit, subtract if it fits
    assign trial    = {r_rem, r_prod[2*W-1]};
    assign rem_next = (trial >= {1'b0, i_modulus}) ? W'(trial - {1'b0, i_modulus})
                                                   : trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base_value;
            r_exp  <= i_exponent;
            r_acc  <= W'(1);
            r_last <= i_is_last;
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
            r_rem  <= '0;
        end
        if (i_cmd.red) begin
            r_prod <= {r_prod[2*W-2:0], 1'b0};
            r_rem  <= rem_next;
        end
        if (i_cmd.wb) begin
            if (i_cmd.op == MUL_ACC_SQ) begin
                r_acc <= r_rem;
            end else begin
                r_sq <= r_rem;
            end
        end
        if (i_cmd.shift) begin
            r_exp <= {1'b0, r_exp[W-1:1]};
        end
        if (i_cmd.res_we) begin
            r_last_out <= r_last;
            case (i_cmd.res_sel)
                RES_BASE: r_result <= r_base;
                RES_ZERO: r_result <= '0;
                RES_ACC:  r_result <= r_acc;
                default:  r_result <= '0;
            endcase
        end
    end

    assign o_stat.exp_lt2     = (i_exponent[W-1:1] == '0);
    assign o_stat.mod_lt2     = (i_modulus[W-1:1] == '0);
    assign o_stat.exp_lsb     = r_exp[0];
    assign o_stat.exp_hi_zero = (r_exp[W-1:1] == '0);

    assign o_power_value = r_result;
    assign o_last_out    = r_last_out;

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.red && !o_stat.mod_lt2) |=> r_rem < i_modulus)
        else $error("remainder not reduced");

    a_wb_after_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> $past(i_cmd.red))
        else $error("write-back without reduction");

endmodule

`default_nettype wire

// ===== tb/modular_exponentiation_unit_tb.sv =====
// self-checking testbench for modular_exponentiation_unit: directed corner requests, then
// random exponent / modulus settings; depends on modexp_pkg and the unit's rtl
`timescale 1ns / 100ps

module modular_exponentiation_unit_tb;
    import modexp_pkg::*;

    localparam int VALUE_W    = 32;
    localparam int TIMEOUT_NS = 50_000_000;

    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] power_value;
        logic               last_out;
    } t_power_result;

    class modexp_scoreboard;
        logic [CFG_DATA_W-1:0] exponent_reg;
        logic [CFG_DATA_W-1:0] modulus_reg;
        t_power_result         expected_powers[$];
        int                    error_count;

        function new();
            exponent_reg = EXPONENT_RESET;
            modulus_reg  = MODULUS_RESET;
            error_count  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EXPONENT: exponent_reg = data;
                CFG_MODULUS:  modulus_reg  = data;
                default: ;
            endcase
        endfunction

        // square-and-multiply, every product reduced
        function logic [VALUE_W-1:0] mod_power(logic [VALUE_W-1:0] base);
            logic [63:0]          acc;
            logic [63:0]          sq;
            logic [63:0]          m;
            logic [VALUE_W-1:0]   e;
            if (exponent_reg < 2) return base;
            if (modulus_reg < 2) return '0;
            m   = 64'(modulus_reg);
            acc = 64'd1;
            sq  = 64'(base) % m;
            e   = exponent_reg[VALUE_W-1:0];
            while (e != 0) begin
                if (e[0]) acc = (acc * sq) % m;
                sq = (sq * sq) % m;
                e  = e >> 1;
            end
            return acc[VALUE_W-1:0];
        endfunction

        function void note_request(logic [VALUE_W-1:0] base, logic last);
            t_power_result r;
            r.power_value = mod_power(base);
            r.last_out    = last;
            expected_powers.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            error_count++;
        endtask

        task check_result(logic [VALUE_W-1:0] power, logic last);
            t_power_result want;
            if (expected_powers.size() == 0) begin
                report($sformatf("result %h with no request pending", power));
            end else begin
                want = expected_powers.pop_front();
                if (power !== want.power_value)
                    report($sformatf("power_value %h, expected %h", power, want.power_value));
                if (last !== want.last_out)
                    report($sformatf("last_out %b, expected %b", last, want.last_out));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_start       = 1'b0;
    logic [VALUE_W-1:0]    i_base_value  = '0;
    logic                  i_is_last     = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [VALUE_W-1:0]    o_power_value;
    logic                  o_last_out;

    modexp_scoreboard sb = new();
    int sender_idle_pct = 17;

    modular_exponentiation_unit #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_base_value  (i_base_value),
        .i_is_last     (i_is_last),
        .o_busy        (o_busy),
        .o_done        (o_done),
        .o_power_value (o_power_value),
        .o_last_out    (o_last_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[modular_exponentiation_unit] ERROR");
        $finish;
    end

    // everything here sees the values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_start && !o_busy) sb.note_request(i_base_value, i_is_last);
            if (o_done) sb.check_result(o_power_value, o_last_out);
        end
    end

    task send_request(input logic [VALUE_W-1:0] base, input logic last);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct) gap++;
        if ($urandom_range(0, 399) < sender_idle_pct) gap += $urandom_range(0, 150);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_base_value <= base;
        i_is_last    <= last;
        do @(posedge i_clk); while (o_busy);
    endtask

    task drain_requests();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_powers.size() != 0 || o_busy) @(posedge i_clk);
    endtask

    task write_regs(input logic [CFG_DATA_W-1:0] exp_val, input logic [CFG_DATA_W-1:0] mod_val,
                    input bit spare);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EXPONENT;
        i_cfg_data  <= exp_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_MODULUS;
        i_cfg_data  <= mod_val;
        @(posedge i_clk);
        if (spare) begin
            i_cfg_index <= CFG_SPARE_LO;
            i_cfg_data  <= $urandom;
            @(posedge i_clk);
            i_cfg_index <= CFG_SPARE_HI;
            i_cfg_data  <= $urandom;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task run_random_mode(input int pct, input int item_target);
        int                  sent;
        int                  n;
        logic [VALUE_W-1:0]  exp_val;
        logic [VALUE_W-1:0]  mod_val;
        logic [VALUE_W-1:0]  base;
        sender_idle_pct = pct;
        sent = 0;
        while (sent < item_target) begin
            // keep most exponents short, a full-width one now and then
            case ($urandom_range(0, 9))
                0: exp_val = $urandom_range(0, 1);
                1: exp_val = $urandom_range(0, 1) ? {VALUE_W{1'b1}} : $urandom;
                2: exp_val = $urandom_range(2, 3);
                default: exp_val = $urandom >> $urandom_range(16, 30);
            endcase
            case ($urandom_range(0, 9))
                0: mod_val = $urandom_range(0, 1);
                1: mod_val = {VALUE_W{1'b1}};
                2: mod_val = $urandom_range(2, 20);
                3: mod_val = $urandom >> $urandom_range(1, 28);
                default: mod_val = $urandom;
            endcase
            write_regs(exp_val, mod_val, $urandom_range(0, 3) == 0);
            n = $urandom_range(4, 12);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0: base = $urandom_range(0, 1);
                    1: base = {VALUE_W{1'b1}};
                    2: base = mod_val - 1;
                    3: base = mod_val + $urandom_range(0, 3);
                    4: base = $urandom >> $urandom_range(1, 31);
                    default: base = $urandom;
                endcase
                send_request(base, $urandom_range(0, 1));
            end
            sent += n;
            drain_requests();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at their reset values
        send_request(0, 1'b0);
        send_request(1, 1'b0);
        send_request(65, 1'b0);
        send_request(3232, 1'b0);
        send_request(3233, 1'b0);
        send_request({VALUE_W{1'b1}}, 1'b1);
        drain_requests();

        // exponent zero and one: base comes back unreduced
        write_regs(0, 3233, 1'b1);
        send_request({VALUE_W{1'b1}}, 1'b0);
        send_request(32'h1234_5678, 1'b1);
        drain_requests();
        write_regs(1, 7, 1'b0);
        send_request(100, 1'b0);
        send_request(0, 1'b1);
        drain_requests();

        // modulus one and zero give zero, unless the exponent is below two
        write_regs(2, 1, 1'b0);
        send_request(5, 1'b0);
        send_request({VALUE_W{1'b1}}, 1'b1);
        drain_requests();
        write_regs(3, 0, 1'b0);
        send_request(5, 1'b1);
        drain_requests();
        write_regs(0, 0, 1'b0);
        send_request(9, 1'b1);
        drain_requests();

        write_regs(2, 2, 1'b0);
        send_request({VALUE_W{1'b1}}, 1'b0);
        send_request(2, 1'b1);
        drain_requests();

        // full-width exponent and modulus, then exponent 65537 with a full-width modulus
        write_regs({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 1'b0);
        send_request(32'hFFFF_FFFE, 1'b0);
        send_request({VALUE_W{1'b1}}, 1'b1);
        send_request(2, 1'b0);
        drain_requests();
        write_regs(65537, 32'hFFFF_FFFB, 1'b1);
        send_request(32'hFFFF_FFFA, 1'b1);
        send_request(3, 1'b0);
        drain_requests();

        run_random_mode(17, 36);
        run_random_mode(48, 36);
        run_random_mode(0, 36);

        drain_requests();
        repeat (10) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("[modular_exponentiation_unit] OK");
        end else begin
            $display("[modular_exponentiation_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/modexp_pkg.sv
rtl/modexp_ctrl.sv
rtl/modexp_dp.sv
rtl/modular_exponentiation_unit.sv
tb/modular_exponentiation_unit_tb.sv
